>>> sv/bpfs_pkg.sv
// ----------------------------------------------------------------------------
// bpfs_pkg
// Shared types and constants of the block pool free stack allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfs_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS = 1024;
  localparam int MAX_ALLOC  = 64;
  localparam int ID_W       = $clog2(MAX_BLOCKS);
  localparam int DEPTH_W    = $clog2(MAX_BLOCKS + 1);
  localparam int CNT_W      = 7;
  localparam int TOK_W      = 20;
  localparam int BS_W       = 16;
  localparam int REQ_W      = 2;
  localparam int ST_W       = 3;

  // Register reset values.
  localparam logic [DEPTH_W-1:0] POOL_RESET = DEPTH_W'(1024);
  localparam logic [BS_W-1:0]    BS_RESET   = BS_W'(16);

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_POOL_BLOCKS = 1'b0;
  localparam logic REG_BLOCK_SIZE  = 1'b1;

  // Queue depths.
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 4;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_SHORT    = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_ID   = 3'd2;
  localparam logic [ST_W-1:0] ST_ALREADY  = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  block_id;
    logic [TOK_W-1:0] token_count;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    block_out;
    logic               id_valid;
    logic [ST_W-1:0]    status;
    logic [DEPTH_W-1:0] free_total;
    logic [TOK_W-1:0]   blocks_needed;
    logic               fits;
    logic               last;
  } out_item_t;

  // Classified command between the front and the back end.
  typedef struct packed {
    op_t              op;
    logic             over_max;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  block_id;
    logic [TOK_W-1:0] token_count;
  } cmd_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] pool_blocks;
    logic [BS_W-1:0]    blk_tokens;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [TOK_W-1:0] dividend;
    logic [BS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TOK_W-1:0] need;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> sv/block_pool_free_stack_allocator.sv
// ----------------------------------------------------------------------------
// block_pool_free_stack_allocator
// Fixed-size block pool allocator kept as a stack of free block ids.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter as items through push/full and are held in a two-entry
// command queue; results leave through empty/pop from a four-entry result
// queue, so the requester and the consumer stall independently.
// An allocate of N ids keeps the back end busy while it takes the command,
// then per id does a stack memory read followed by delivery of the id. A
// free does one free-flag memory read, then the check; a size query waits
// on the 20-step iterative divider, and a pool reset only sets the stack state.
// Configuration goes through the APB port: pool_blocks at 0x0, the block
// size register at 0x4; pool_blocks takes effect at the next pool reset.
// After rst the pool holds 1024 free blocks with block 0 on top; there is no
// clearing pass, the block accepts items at once. When the consumer stops
// popping, the result queue fills, the back end holds its current item and
// full rises once the command queue is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module block_pool_free_stack_allocator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire bpfs_pkg::in_item_t               req,
  output logic                                  empty,
  input  wire logic                             pop,
  output bpfs_pkg::out_item_t                   rsp,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bpfs_pkg::CFG_AW-1:0]      paddr,
  input  wire logic [bpfs_pkg::CFG_DW-1:0]      pwdata,
  output logic [bpfs_pkg::CFG_DW-1:0]           prdata,
  output logic                                  pready
);

  bpfs_pkg::cfg_t      cfg;
  bpfs_pkg::cmd_t      cmd;
  bpfs_pkg::div_req_t  dreq;
  bpfs_pkg::div_rsp_t  drsp;
  bpfs_pkg::out_item_t rq_item;
  logic cmd_valid, cmd_pop, rq_push, rq_full;
  logic wr_en;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_blocks <= bpfs_pkg::POOL_RESET;
      cfg.blk_tokens  <= bpfs_pkg::BS_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        bpfs_pkg::REG_POOL_BLOCKS: cfg.pool_blocks <= pwdata[bpfs_pkg::DEPTH_W-1:0];
        bpfs_pkg::REG_BLOCK_SIZE:  cfg.blk_tokens  <= pwdata[bpfs_pkg::BS_W-1:0];
        default: cfg <= cfg;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[2])
      bpfs_pkg::REG_POOL_BLOCKS: prdata = bpfs_pkg::CFG_DW'(cfg.pool_blocks);
      bpfs_pkg::REG_BLOCK_SIZE:  prdata = bpfs_pkg::CFG_DW'(cfg.blk_tokens);
      default:                   prdata = '0;
    endcase
  end

  bpfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  bpfs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  bpfs_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .dreq      (dreq),
    .drsp      (drsp),
    .rq_push   (rq_push),
    .rq_item   (rq_item),
    .rq_full   (rq_full)
  );

  bpfs_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .item  (rq_item),
    .full  (rq_full),
    .empty (empty),
    .pop   (pop),
    .head  (rsp)
  );

endmodule

`default_nettype wire

>>> sv/bpfs_front.sv
// ----------------------------------------------------------------------------
// bpfs_front
// Accepts request items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire bpfs_pkg::in_item_t req,
  output logic                    cmd_valid,
  input  wire logic               cmd_pop,
  output bpfs_pkg::cmd_t          cmd
);

  localparam int PW = $clog2(bpfs_pkg::CMDQ_DEPTH);
  localparam int CW = $clog2(bpfs_pkg::CMDQ_DEPTH + 1);

  bpfs_pkg::cmd_t q [bpfs_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  bpfs_pkg::cmd_t cls;
  logic do_push;
  logic do_pop;

  // Decode the request kind and flag counts above the allocation cap.
  always_comb begin
    cls.op          = bpfs_pkg::op_t'(req.req_type);
    cls.over_max    = (req.count > bpfs_pkg::CNT_W'(bpfs_pkg::MAX_ALLOC));
    cls.count       = req.count;
    cls.block_id    = req.block_id;
    cls.token_count = req.token_count;
  end

  assign full      = (fill == CW'(bpfs_pkg::CMDQ_DEPTH));
  assign cmd_valid = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (!do_push && do_pop) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/bpfs_div.sv
// ----------------------------------------------------------------------------
// bpfs_div
// Iterative restoring divider giving the rounded-up block count of a query.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bpfs_pkg::div_req_t dreq,
  output bpfs_pkg::div_rsp_t      drsp
);

  localparam int TW = bpfs_pkg::TOK_W;
  localparam int BW = bpfs_pkg::BS_W;
  localparam int KW = $clog2(TW);

  logic          busy;
  logic          done;
  logic [KW-1:0] step;
  logic [TW-1:0] quo;
  logic [BW-1:0] rem;
  logic [BW-1:0] dvs;
  logic [BW:0]   trial;
  logic          ge;
  logic [BW:0]   diff;

  // One quotient bit per cycle.
  assign trial = {rem, quo[TW-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  // Round up when a remainder is left.
  assign drsp.done = done;
  assign drsp.need = quo + TW'(rem != '0);

  always_ff @(posedge clk) begin
    if (dreq.start) begin
      quo <= dreq.dividend;
      rem <= '0;
      dvs <= (dreq.divisor == '0) ? BW'(1) : dreq.divisor;
    end else if (busy) begin
      quo <= {quo[TW-2:0], ge};
      rem <= ge ? diff[BW-1:0] : trial[BW-1:0];
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (dreq.start) begin
        busy <= 1'b1;
        step <= KW'(TW - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - KW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/bpfs_resq.sv
// ----------------------------------------------------------------------------
// bpfs_resq
// Result queue that parts the back end from the result consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_resq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bpfs_pkg::out_item_t item,
  output logic                     full,
  output logic                     empty,
  input  wire logic                pop,
  output bpfs_pkg::out_item_t      head
);

  localparam int PW = $clog2(bpfs_pkg::RESQ_DEPTH);
  localparam int CW = $clog2(bpfs_pkg::RESQ_DEPTH + 1);

  bpfs_pkg::out_item_t q [bpfs_pkg::RESQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic do_push;
  logic do_pop;

  assign full    = (fill == CW'(bpfs_pkg::RESQ_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (!do_push && do_pop) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/bpfs_exec.sv
// ----------------------------------------------------------------------------
// bpfs_exec
// Back end: runs allocate, free, pool reset and query commands on the stack.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_exec (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bpfs_pkg::cfg_t      cfg,
  input  wire logic                cmd_valid,
  output logic                     cmd_pop,
  input  wire bpfs_pkg::cmd_t      cmd,
  output bpfs_pkg::div_req_t       dreq,
  input  wire bpfs_pkg::div_rsp_t  drsp,
  output logic                     rq_push,
  output bpfs_pkg::out_item_t      rq_item,
  input  wire logic                rq_full
);

  localparam int IW = bpfs_pkg::ID_W;
  localparam int DW = bpfs_pkg::DEPTH_W;
  localparam int CW = bpfs_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ARD  = 6'b000010,
    S_AWR  = 6'b000100,
    S_FCHK = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  // Stack bookkeeping. Entries below low_mark still hold the fill pattern
  // (id = active - 1 - index); their memory contents are never used.
  logic [DW-1:0] depth, depth_next;
  logic [DW-1:0] low_mark, low_mark_next;
  logic [DW-1:0] active, active_next;
  logic [CW-1:0] remaining, remaining_next;
  logic          virt, virt_next;
  logic [IW-1:0] vval, vval_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] id, id_next;
  bpfs_pkg::out_item_t res, res_next;

  // Memories: the free stack and a per-id free flag.
  logic [IW-1:0] sm [bpfs_pkg::MAX_BLOCKS];
  logic          fm [bpfs_pkg::MAX_BLOCKS];
  logic          sm_we, sm_re, fm_we, fm_re, fm_wd;
  logic [IW-1:0] sm_wa, sm_ra, sm_wd, fm_wa, fm_ra;
  logic [IW-1:0] sm_q;
  logic          fm_q;

  logic [DW-1:0] pool_clamped;
  logic [DW-1:0] top_idx;
  logic [IW-1:0] blk;
  logic          on_stack;

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm[sm_wa] <= sm_wd;
    end
    if (sm_re) begin
      sm_q <= sm[sm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (fm_we) begin
      fm[fm_wa] <= fm_wd;
    end
    if (fm_re) begin
      fm_q <= fm[fm_ra];
    end
  end

  // Pool size as applied by a reset request.
  always_comb begin
    if (cfg.pool_blocks == '0) begin
      pool_clamped = DW'(1);
    end else if (cfg.pool_blocks > DW'(bpfs_pkg::MAX_BLOCKS)) begin
      pool_clamped = DW'(bpfs_pkg::MAX_BLOCKS);
    end else begin
      pool_clamped = cfg.pool_blocks;
    end
  end

  assign top_idx = depth - DW'(1);
  assign blk     = virt ? vval : sm_q;
  // Ids at or above active - low_mark were never popped since the last fill.
  assign on_stack = ({1'b0, id} >= (active - low_mark)) || fm_q;

  // Command sequencer.
  always_comb begin
    state_next     = state;
    depth_next     = depth;
    low_mark_next  = low_mark;
    active_next    = active;
    remaining_next = remaining;
    virt_next      = virt;
    vval_next      = vval;
    count_next     = count;
    id_next        = id;
    res_next       = res;
    cmd_pop        = 1'b0;
    sm_we = 1'b0; sm_re = 1'b0; fm_we = 1'b0; fm_re = 1'b0; fm_wd = 1'b0;
    sm_wa = '0; sm_ra = '0; sm_wd = '0; fm_wa = '0; fm_ra = '0;
    rq_push        = 1'b0;
    rq_item        = res;
    dreq.start     = 1'b0;
    dreq.dividend  = cmd.token_count;
    dreq.divisor   = cfg.blk_tokens;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop       = 1'b1;
          count_next    = cmd.count;
          id_next       = cmd.block_id;
          res_next      = '0;
          res_next.last = 1'b1;
          case (cmd.op)
            bpfs_pkg::OP_ALLOC: begin
              if (cmd.over_max || (DW'(cmd.count) > depth)) begin
                res_next.status = bpfs_pkg::ST_SHORT;
                state_next      = S_EMIT;
              end else if (cmd.count == '0) begin
                res_next.fits = 1'b1;
                state_next    = S_EMIT;
              end else begin
                remaining_next = cmd.count;
                state_next     = S_ARD;
              end
            end
            bpfs_pkg::OP_FREE: begin
              if ({1'b0, cmd.block_id} >= active) begin
                res_next.status = bpfs_pkg::ST_BAD_ID;
                state_next      = S_EMIT;
              end else begin
                fm_re      = 1'b1;
                fm_ra      = cmd.block_id;
                state_next = S_FCHK;
              end
            end
            bpfs_pkg::OP_RESET: begin
              active_next   = pool_clamped;
              depth_next    = pool_clamped;
              low_mark_next = pool_clamped;
              state_next    = S_EMIT;
            end
            bpfs_pkg::OP_QUERY: begin
              dreq.start = 1'b1;
              state_next = S_DIV;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // Pop one id: read the top entry, or take it from the fill pattern.
      S_ARD: begin
        sm_re      = 1'b1;
        sm_ra      = top_idx[IW-1:0];
        virt_next  = (top_idx < low_mark);
        vval_next  = IW'(active - DW'(1) - top_idx);
        depth_next = top_idx;
        if (top_idx < low_mark) begin
          low_mark_next = top_idx;
        end
        state_next = S_AWR;
      end

      // Deliver the popped id and mark it allocated.
      S_AWR: begin
        if (!rq_full) begin
          rq_push                = 1'b1;
          rq_item                = '0;
          rq_item.block_out      = blk;
          rq_item.id_valid       = 1'b1;
          rq_item.fits           = 1'b1;
          rq_item.last           = (remaining == CW'(1));
          rq_item.free_total     = depth;
          fm_we                  = 1'b1;
          fm_wa                  = blk;
          fm_wd                  = 1'b0;
          remaining_next         = remaining - CW'(1);
          state_next             = (remaining == CW'(1)) ? S_IDLE : S_ARD;
        end
      end

      // Free checks in order: double free, then a full stack.
      S_FCHK: begin
        if (on_stack) begin
          res_next.status = bpfs_pkg::ST_ALREADY;
        end else if (depth >= active) begin
          res_next.status = bpfs_pkg::ST_OVERFLOW;
        end else begin
          sm_we      = 1'b1;
          sm_wa      = depth[IW-1:0];
          sm_wd      = id;
          fm_we      = 1'b1;
          fm_wa      = id;
          fm_wd      = 1'b1;
          depth_next = depth + DW'(1);
        end
        state_next = S_EMIT;
      end

      S_DIV: begin
        if (drsp.done) begin
          res_next.blocks_needed = drsp.need;
          res_next.fits          = (DW'(count) <= depth);
          state_next             = S_EMIT;
        end
      end

      // Single-result commands report the depth they leave behind.
      S_EMIT: begin
        if (!rq_full) begin
          rq_push            = 1'b1;
          rq_item            = res;
          rq_item.free_total = depth;
          state_next         = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= bpfs_pkg::POOL_RESET;
      low_mark  <= bpfs_pkg::POOL_RESET;
      active    <= bpfs_pkg::POOL_RESET;
      remaining <= '0;
    end else begin
      state     <= state_next;
      depth     <= depth_next;
      low_mark  <= low_mark_next;
      active    <= active_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    virt  <= virt_next;
    vval  <= vval_next;
    count <= count_next;
    id    <= id_next;
    res   <= res_next;
  end

endmodule

`default_nettype wire

>>> sv/bpfs_checker.sv
// ----------------------------------------------------------------------------
// bpfs_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfs_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire bpfs_pkg::out_item_t rsp
);

  // Reset leaves the result queue empty and the command queue not full.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A delivered id is always a successful result.
  a_id_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.id_valid) |-> (rsp.status == bpfs_pkg::ST_OK && rsp.fits))
    else $error("allocated id with failing status");

  // Results without an id carry a zero block number.
  a_no_id_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !rsp.id_valid) |-> (rsp.block_out == '0))
    else $error("block number without id_valid");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rsp.status <= bpfs_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  // A waiting result that is not taken stays on the ports.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(rsp)))
    else $error("waiting result changed");

endmodule

bind block_pool_free_stack_allocator bpfs_checker u_bpfs_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .rsp   (rsp)
);

`default_nettype wire
